[design/mhpq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mhpq_pkg
// shared types and codes for the binary min-heap priority queue
// ----------------------------------------------------------------------------
package mhpq_pkg;

   localparam int KEY_W = 32;
   localparam int OCC_W = 5;
   localparam int STATUS_W = 2;

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_EXTRACT = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   localparam logic signed [KEY_W-1:0] EMPTY_VALUE = 32'sh7FFF_FFFF;

   typedef struct packed {
      logic mode;
      logic signed [KEY_W-1:0] key;
   } req_type;

   typedef struct packed {
      logic signed [KEY_W-1:0] value;
      logic [STATUS_W-1:0] status;
      logic [OCC_W-1:0] occupancy;
   } rsp_type;

endpackage : mhpq_pkg
`default_nettype wire

[design/mhpq_store.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mhpq_store
// heap key storage: one write port, two registered read ports
// ----------------------------------------------------------------------------
module mhpq_store
   import mhpq_pkg::*;
#(
   parameter int DEPTH = 16,
   parameter int AW = 4
) (
   input wire logic clock,
   input wire logic wr_en,
   input wire logic [AW-1:0] wr_addr,
   input wire logic signed [KEY_W-1:0] wr_data,
   input wire logic rd_en,
   input wire logic [AW-1:0] rd_addr_a,
   input wire logic [AW-1:0] rd_addr_b,
   output logic signed [KEY_W-1:0] rd_data_a,
   output logic signed [KEY_W-1:0] rd_data_b
);

   logic signed [KEY_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a <= mem[rd_addr_a];
         rd_data_b <= mem[rd_addr_b];
      end
   end

endmodule : mhpq_store
`default_nettype wire

[design/min_heap_priority_queue_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// min_heap_priority_queue_unit
// binary min-heap of signed 32-bit keys with insert and extract-minimum
// ----------------------------------------------------------------------------
// latency depends on the path: a dropped insert or an empty extract answers in idle;
//   the last key answers from S_EXT_LD; an insert climbs by S_UP_RD, S_UP_CMP per level,
//   an extract sinks by S_DN_RD, S_DN_CMP per level after S_EXT_RD, S_EXT_LD; then S_FIN
// throughput: one request at a time, busy drops as the result strobe is registered
// the receiver cannot stall, rsp_valid is a single-cycle strobe
// reset: synchronous, clears the key count and the controller, not the store
module min_heap_priority_queue_unit
   import mhpq_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   output logic busy,
   input wire req_type req_item,
   output logic rsp_valid,
   output rsp_type rsp_item
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = AW + 2;

   // controller state codes
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_UP_RD = 3'd1;
   localparam logic [2:0] S_UP_CMP = 3'd2;
   localparam logic [2:0] S_EXT_RD = 3'd3;
   localparam logic [2:0] S_EXT_LD = 3'd4;
   localparam logic [2:0] S_DN_RD = 3'd5;
   localparam logic [2:0] S_DN_CMP = 3'd6;
   localparam logic [2:0] S_FIN = 3'd7;

   // control registers
   logic [2:0] state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic rsp_valid_ff, rsp_valid_in;

   // datapath registers
   logic [AW-1:0] pos_ff, pos_in;          // hole being moved through the heap
   logic signed [KEY_W-1:0] key_ff, key_in; // key that travels with the hole
   logic signed [KEY_W-1:0] value_ff, value_in;
   logic rc_ok_ff, rc_ok_in;               // right child exists
   rsp_type rsp_ff, rsp_in;

   // store ports
   logic wr_en;
   logic [AW-1:0] wr_addr;
   logic signed [KEY_W-1:0] wr_data;
   logic rd_en;
   logic [AW-1:0] rd_addr_a, rd_addr_b;
   logic signed [KEY_W-1:0] rd_data_a, rd_data_b;

   // index arithmetic
   logic [AW-1:0] parent_idx;
   logic [XW-1:0] pos_x, count_x, left_x, right_x;
   logic [AW-1:0] left_idx, right_idx;
   logic take_right;
   logic signed [KEY_W-1:0] best_key;
   logic [AW-1:0] best_idx;
   logic accept;

   mhpq_store #(
      .DEPTH(CAPACITY),
      .AW(AW)
   ) u_store (
      .clock(clock),
      .wr_en(wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en(rd_en),
      .rd_addr_a(rd_addr_a),
      .rd_addr_b(rd_addr_b),
      .rd_data_a(rd_data_a),
      .rd_data_b(rd_data_b)
   );

   assign busy = (state_ff != S_IDLE);
   assign accept = start && !busy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item = rsp_ff;

   // parent (i-1)/2 and children 2i+1, 2i+2, children kept two bits wider
   assign parent_idx = AW'((pos_ff - AW'(1)) >> 1);
   assign pos_x = XW'(pos_ff);
   assign count_x = XW'(count_ff);
   assign left_x = (pos_x << 1) + XW'(1);
   assign right_x = (pos_x << 1) + XW'(2);
   assign left_idx = left_x[AW-1:0];
   assign right_idx = right_x[AW-1:0];

   // smaller child that exists, left wins a tie
   assign take_right = rc_ok_ff && (rd_data_b < rd_data_a);
   assign best_key = take_right ? rd_data_b : rd_data_a;
   assign best_idx = take_right ? right_idx : left_idx;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      pos_in = pos_ff;
      key_in = key_ff;
      value_in = value_ff;
      rc_ok_in = rc_ok_ff;
      rsp_valid_in = 1'b0;
      rsp_in = rsp_ff;
      wr_en = 1'b0;
      wr_addr = pos_ff;
      wr_data = key_ff;
      rd_en = 1'b0;
      rd_addr_a = '0;
      rd_addr_b = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_item.mode == MODE_INSERT) begin
                  if (count_ff == CW'(CAPACITY)) begin
                     // full: drop the key, answer at once
                     rsp_valid_in = 1'b1;
                     rsp_in.value = '0;
                     rsp_in.status = STATUS_FULL;
                     rsp_in.occupancy = OCC_W'(count_ff);
                  end else begin
                     pos_in = count_ff[AW-1:0];
                     count_in = count_ff + CW'(1);
                     key_in = req_item.key;
                     value_in = '0;
                     state_in = (count_ff == '0) ? S_FIN : S_UP_RD;
                  end
               end else begin
                  if (count_ff == '0) begin
                     rsp_valid_in = 1'b1;
                     rsp_in.value = EMPTY_VALUE;
                     rsp_in.status = STATUS_EMPTY;
                     rsp_in.occupancy = OCC_W'(count_ff);
                  end else begin
                     state_in = S_EXT_RD;
                  end
               end
            end
         end
         S_UP_RD: begin
            rd_en = 1'b1;
            rd_addr_a = parent_idx;
            state_in = S_UP_CMP;
         end
         S_UP_CMP: begin
            if (key_ff < rd_data_a) begin
               // pull the parent down into the hole
               wr_en = 1'b1;
               wr_data = rd_data_a;
               pos_in = parent_idx;
               state_in = (parent_idx == '0) ? S_FIN : S_UP_RD;
            end else begin
               state_in = S_FIN;
            end
         end
         S_EXT_RD: begin
            // root and last entry together
            rd_en = 1'b1;
            rd_addr_a = '0;
            rd_addr_b = AW'(count_ff - CW'(1));
            count_in = count_ff - CW'(1);
            state_in = S_EXT_LD;
         end
         S_EXT_LD: begin
            value_in = rd_data_a;
            key_in = rd_data_b;
            pos_in = '0;
            if (count_ff == '0) begin
               // last key taken, nothing to restore
               rsp_valid_in = 1'b1;
               rsp_in.value = rd_data_a;
               rsp_in.status = STATUS_OK;
               rsp_in.occupancy = OCC_W'(count_ff);
               state_in = S_IDLE;
            end else begin
               state_in = S_DN_RD;
            end
         end
         S_DN_RD: begin
            if (left_x >= count_x) begin
               state_in = S_FIN;
            end else begin
               rd_en = 1'b1;
               rd_addr_a = left_idx;
               rc_ok_in = (right_x < count_x);
               rd_addr_b = (right_x < count_x) ? right_idx : left_idx;
               state_in = S_DN_CMP;
            end
         end
         S_DN_CMP: begin
            if (best_key < key_ff) begin
               // push the smaller child up into the hole
               wr_en = 1'b1;
               wr_data = best_key;
               pos_in = best_idx;
               state_in = S_DN_RD;
            end else begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            // settle the travelling key and report
            wr_en = 1'b1;
            rsp_valid_in = 1'b1;
            rsp_in.value = value_ff;
            rsp_in.status = STATUS_OK;
            rsp_in.occupancy = OCC_W'(count_ff);
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      key_ff <= key_in;
      value_ff <= value_in;
      rc_ok_ff <= rc_ok_in;
      rsp_ff <= rsp_in;
   end

`ifndef SYNTH
   // a result only shows once the controller is back in idle
   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   // the key count never passes the capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("key count above capacity");

   // an accepted request either answers at once or occupies the controller
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      accept |=> (busy || rsp_valid))
      else $error("accepted request lost");

   // a dropped insert only happens on a full heap
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_item.status == STATUS_FULL)) |-> (count_ff == CW'(CAPACITY)))
      else $error("full status with free slots");
`endif

endmodule : min_heap_priority_queue_unit
`default_nettype wire
